/* hw/rtl/aging_destination_table_unit_macros.svh */
// assertion macros shared by the aging destination table rtl
`ifndef AGING_DESTINATION_TABLE_UNIT_MACROS_SVH
`define AGING_DESTINATION_TABLE_UNIT_MACROS_SVH

// same-cycle implication, checked on every rising clk outside reset
`define ADT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every rising clk outside reset
`define ADT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/adt_pkg.sv */
// shared types and constants of the aging destination table
package adt_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 16;
  localparam int unsigned QUEUE_DEPTH       = 2;
  localparam logic [31:0] FRESH_WINDOW_RESET = 32'd1500;

  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_INSERT  = 2'd0,
    ST_UPDATE  = 2'd1,
    ST_REPLACE = 2'd2,
    ST_DROP    = 2'd3
  } status_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_SCAN = 1'b1
  } bk_state_t;

  typedef struct packed {
    logic        func;
    logic [31:0] now_time;
    logic [31:0] dest_addr;
    logic [7:0]  hop_distance;
    logic [7:0]  prev_hop_distance;
  } in_item_t;

  typedef struct packed {
    logic [1:0] record_status;
    logic       found;
    logic [7:0] found_distance;
    logic       closer;
  } out_item_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [7:0]  distance;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    op_t      op;
    in_item_t item;
  } q_ent_t;

  typedef struct packed {
    logic   valid;
    q_ent_t ent;
  } head_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_t;

endpackage

/* hw/rtl/adt_ram.sv */
// generic single write, single registered read ram
module adt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/adt_front.sv */
// input side: accepts items, decodes the operation and queues them
module adt_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  adt_pkg::in_item_t item,
  output logic              full,
  output adt_pkg::head_t    head,
  input  logic              take
);

  localparam int unsigned QD = adt_pkg::QUEUE_DEPTH;
  localparam int unsigned QW = (QD > 1) ? $clog2(QD) : 1;
  localparam int unsigned CW = $clog2(QD + 1);

  adt_pkg::q_ent_t q_mem_r [QD];
  logic [QW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;
  adt_pkg::q_ent_t new_ent;

  assign full    = (cnt_r == CW'(QD));
  assign do_push = push && !full;
  assign do_pop  = take && (cnt_r != '0);

  // classify the item by its function code
  always_comb begin
    new_ent.item = item;
    new_ent.op   = item.func ? adt_pkg::OP_LOOKUP : adt_pkg::OP_RECORD;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QW'(QD - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QW'(QD - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wr_ptr_r] <= new_ent;
    end
  end

  assign head.valid = (cnt_r != '0);
  assign head.ent   = q_mem_r[rd_ptr_r];

endmodule

/* hw/rtl/adt_back.sv */
// table side: scans the entry ram one slot per cycle and applies the item
`include "aging_destination_table_unit_macros.svh"

module adt_back #(
  parameter int unsigned TABLE_ENTRIES = adt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  adt_pkg::head_t head,
  output logic           take,
  input  logic [31:0]    fresh_window,
  input  logic           out_free,
  output adt_pkg::res_t  res
);

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned EW = $bits(adt_pkg::entry_t);

  adt_pkg::bk_state_t state_r, state_nxt;
  logic [IW-1:0]      c_r, c_nxt;
  logic [CW-1:0]      fill_r, fill_nxt;
  logic               have_r, have_nxt;
  logic [IW-1:0]      spot_r, spot_nxt;
  adt_pkg::in_item_t  item_r, item_nxt;
  adt_pkg::op_t       op_r, op_nxt;

  logic               start, done;
  logic               wr_en;
  logic [IW-1:0]      wr_idx, rd_addr;
  logic [EW-1:0]      rd_raw;
  adt_pkg::entry_t    rd_ent, wr_ent;
  logic               slot_empty, slot_match, slot_fresh, last;
  logic [31:0]        age;

  assign rd_ent     = adt_pkg::entry_t'(rd_raw);
  assign slot_empty = (CW'(c_r) >= fill_r);
  assign slot_match = (rd_ent.addr == item_r.dest_addr);
  assign age        = item_r.now_time - rd_ent.stamp;
  assign slot_fresh = (age <= fresh_window);
  assign last       = (c_r == IW'(TABLE_ENTRIES - 1));
  assign start      = head.valid && out_free;

  always_comb begin
    wr_ent.addr     = item_r.dest_addr;
    wr_ent.distance = item_r.hop_distance;
    wr_ent.stamp    = item_r.now_time;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      adt_pkg::BK_IDLE: begin
        if (start) begin
          state_nxt = adt_pkg::BK_SCAN;
        end
      end
      adt_pkg::BK_SCAN: begin
        if (done) begin
          state_nxt = adt_pkg::BK_IDLE;
        end
      end
      default: state_nxt = adt_pkg::BK_IDLE;
    endcase
  end

  // scan decisions
  always_comb begin
    take      = 1'b0;
    done      = 1'b0;
    wr_en     = 1'b0;
    wr_idx    = c_r;
    rd_addr   = '0;
    c_nxt     = c_r;
    fill_nxt  = fill_r;
    have_nxt  = have_r;
    spot_nxt  = spot_r;
    item_nxt  = item_r;
    op_nxt    = op_r;
    res.item  = '0;
    case (state_r)
      adt_pkg::BK_IDLE: begin
        if (start) begin
          take     = 1'b1;
          item_nxt = head.ent.item;
          op_nxt   = head.ent.op;
          c_nxt    = '0;
          have_nxt = 1'b0;
        end
      end
      adt_pkg::BK_SCAN: begin
        rd_addr = c_r + 1'b1;
        c_nxt   = c_r + 1'b1;
        if (op_r == adt_pkg::OP_RECORD) begin
          if (slot_empty) begin
            done     = 1'b1;
            wr_en    = 1'b1;
            fill_nxt = fill_r + 1'b1;
            res.item.record_status = adt_pkg::ST_INSERT;
          end else if (slot_match) begin
            done  = 1'b1;
            wr_en = 1'b1;
            res.item.record_status = adt_pkg::ST_UPDATE;
          end else begin
            if (!have_r && !slot_fresh) begin
              have_nxt = 1'b1;
              spot_nxt = c_r;
            end
            if (last) begin
              done = 1'b1;
              if (have_r || !slot_fresh) begin
                wr_en  = 1'b1;
                wr_idx = have_r ? spot_r : c_r;
                res.item.record_status = adt_pkg::ST_REPLACE;
              end else begin
                res.item.record_status = adt_pkg::ST_DROP;
              end
            end
          end
        end else begin
          if (slot_empty) begin
            done = 1'b1;
          end else if (slot_match && slot_fresh) begin
            done                    = 1'b1;
            res.item.found          = 1'b1;
            res.item.found_distance = rd_ent.distance;
            res.item.closer         = (rd_ent.distance < item_r.prev_hop_distance);
          end else if (last) begin
            done = 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.valid = done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= adt_pkg::BK_IDLE;
      c_r     <= '0;
      fill_r  <= '0;
      have_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      c_r     <= c_nxt;
      fill_r  <= fill_nxt;
      have_r  <= have_nxt;
    end
  end

  always_ff @(posedge clk) begin
    spot_r <= spot_nxt;
    item_r <= item_nxt;
    op_r   <= op_nxt;
  end

  adt_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx),
    .wdata (EW'(wr_ent)),
    .raddr (rd_addr),
    .rdata (rd_raw)
  );

  `ADT_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= CW'(TABLE_ENTRIES), "fill count past table size")
  `ADT_ASSERT_NOW(a_wr_in_scan, wr_en, state_r == adt_pkg::BK_SCAN, "table write outside scan")
  `ADT_ASSERT_NOW(a_res_room, res.valid, out_free, "result with output buffer busy")
  `ADT_ASSERT_NEXT(a_take_scan, take, state_r == adt_pkg::BK_SCAN && c_r == '0,
                   "taken item did not start scan at slot zero")

endmodule

/* hw/rtl/aging_destination_table_unit.sv */
// top level of the aging destination table
// usage:
//   input queue side: drive in_item and raise in_push; the item is taken on a rising clk
//   where in_push is high and in_full is low. func 0 records dest_addr with hop_distance
//   stamped with now_time, func 1 looks up dest_addr.
//   result queue side: while out_empty is low, out_item holds the oldest result; it is
//   taken on a rising clk where out_pop is high. one result per item, in order.
//   cfg side: cfg_data is written to the fresh window when cfg_valid is high; cfg_ready
//   is always high. write it only while no item is in flight.
// timing: when the back end is idle and the output buffer is free, it takes the item at
//   the input queue head, then scans one table slot per cycle, stopping at the first
//   empty or deciding slot; the result is registered into the output buffer and shows
//   on out_item. the back end takes no new item until the scan of the last one is done.
// reset: synchronous active-low rst_n empties the table (fill count zero), both queues,
//   and sets the fresh window to 1500 ticks.
// stall: a held result blocks the next scan only; the two-entry input queue keeps
//   taking items until it fills.
module aging_destination_table_unit #(
  parameter int unsigned TABLE_ENTRIES = adt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_push,
  input  adt_pkg::in_item_t  in_item,
  output logic               in_full,
  // result channel
  output logic               out_empty,
  input  logic               out_pop,
  output adt_pkg::out_item_t out_item,
  // config channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);

  adt_pkg::head_t     head;
  adt_pkg::res_t      res;
  logic               take;
  logic               out_free;

  // fresh window register
  logic [31:0]        window_r, window_nxt;
  // single-entry output buffer
  logic               out_valid_r, out_valid_nxt;
  adt_pkg::out_item_t out_item_r, out_item_nxt;

  assign cfg_ready  = 1'b1;
  assign window_nxt = (cfg_valid && cfg_ready) ? cfg_data : window_r;

  // the back end only starts a scan when the buffer will be free; it stays free
  // until that scan completes since nothing else fills it
  assign out_free = !out_valid_r || out_pop;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (out_pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end
    if (res.valid) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = res.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= adt_pkg::FRESH_WINDOW_RESET;
      out_valid_r <= 1'b0;
    end else begin
      window_r    <= window_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;

  // front end: accept and classify
  adt_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .item  (in_item),
    .full  (in_full),
    .head  (head),
    .take  (take)
  );

  // back end: table scan and update
  adt_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .take         (take),
    .fresh_window (window_r),
    .out_free     (out_free),
    .res          (res)
  );

endmodule
